// ----- rtl/two_input_edge_skew_timer_core_macros.svh -----
// Assertion shorthands for the edge skew timer checkers.
// All expect clock i_clk; the first two also expect active-low reset i_rst_n.
`ifndef TWO_INPUT_EDGE_SKEW_TIMER_CORE_MACROS_SVH
`define TWO_INPUT_EDGE_SKEW_TIMER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ESTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("edge skew timer check failed");

// Next-cycle implication, ignored while reset is asserted.
`define ESTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("edge skew timer check failed");

// Next-cycle implication that also holds across reset.
`define ESTS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("edge skew timer check failed");

`endif

// ----- rtl/ests_pkg.sv -----
`timescale 1ns / 1ps

package ests_pkg;

    // Tick counter width; ticks arrive on 32-bit fields.
    localparam int TICK_BITS = 32;
    localparam int TICK_W    = (TICK_BITS < 32) ? TICK_BITS : 32;

    typedef logic [TICK_W-1:0] t_tick;

    // Order code bit positions: a set bit means B was not the later one.
    localparam int ORDER_FALL_BIT = 1;
    localparam int ORDER_RISE_BIT = 0;

    // Result queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic        fall_a;
        logic        fall_b;
        logic        rise_a;
        logic        rise_b;
        logic [31:0] fall_time_a;
        logic [31:0] fall_time_b;
        logic [31:0] rise_time_a;
        logic [31:0] rise_time_b;
    } t_in;

    typedef struct packed {
        logic [31:0] fall_gap;
        logic [31:0] rise_gap;
        logic [31:0] total_time;
        logic [1:0]  order_code;
    } t_out;

    // Finished measurement handed from front to back.
    typedef struct packed {
        t_tick       fall_gap;
        t_tick       rise_gap;
        logic [1:0]  order_code;
    } t_meas;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_WAIT_FALL_A = 3'd1,
        PH_WAIT_FALL_B = 3'd2,
        PH_WAIT_RISE   = 3'd3,
        PH_WAIT_RISE_A = 3'd4,
        PH_WAIT_RISE_B = 3'd5
    } t_phase;

    function automatic logic [31:0] tick_to_out(t_tick v);
        return 32'(v);
    endfunction

    function automatic logic [31:0] tick_sum(t_tick a, t_tick b);
        t_tick s;
        s = a + b;
        return 32'(s);
    endfunction

endpackage

// ----- rtl/ests_front.sv -----
`timescale 1ns / 1ps

module ests_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ests_pkg::t_in  i_in_data,
    output logic           o_push_valid,
    input  logic           i_push_ready,
    output ests_pkg::t_meas o_push_data
);

    ests_pkg::t_phase r_phase, n_phase;
    ests_pkg::t_tick  r_fall_a, n_fall_a, r_fall_b, n_fall_b;
    ests_pkg::t_tick  r_rise_a, n_rise_a, r_rise_b, n_rise_b;
    ests_pkg::t_tick  r_gap_fall, n_gap_fall, r_gap_rise, n_gap_rise;

    ests_pkg::t_tick  tfa, tfb, tra, trb;
    logic             accept;
    logic             emit;

    assign tfa = i_in_data.fall_time_a[ests_pkg::TICK_W-1:0];
    assign tfb = i_in_data.fall_time_b[ests_pkg::TICK_W-1:0];
    assign tra = i_in_data.rise_time_a[ests_pkg::TICK_W-1:0];
    assign trb = i_in_data.rise_time_b[ests_pkg::TICK_W-1:0];

    // Stall only when the queue cannot take a possible result.
    assign o_in_ready = i_push_ready;
    assign accept     = i_in_valid && i_push_ready;

    always_comb begin
        n_phase    = r_phase;
        n_fall_a   = r_fall_a;
        n_fall_b   = r_fall_b;
        n_rise_a   = r_rise_a;
        n_rise_b   = r_rise_b;
        n_gap_fall = r_gap_fall;
        n_gap_rise = r_gap_rise;
        emit       = 1'b0;
        if (accept) begin
            unique case (r_phase)
                ests_pkg::PH_WAIT_FALL_A: begin
                    if (i_in_data.rise_b) begin
                        n_phase = ests_pkg::PH_IDLE;
                    end else if (i_in_data.fall_a) begin
                        n_fall_a   = tfa;
                        n_gap_fall = tfa - r_fall_b;
                        n_phase    = ests_pkg::PH_WAIT_RISE;
                    end
                end
                ests_pkg::PH_WAIT_FALL_B: begin
                    if (i_in_data.rise_a) begin
                        n_phase = ests_pkg::PH_IDLE;
                    end else if (i_in_data.fall_b) begin
                        n_fall_b   = tfb;
                        n_gap_fall = tfb - r_fall_a;
                        n_phase    = ests_pkg::PH_WAIT_RISE;
                    end
                end
                ests_pkg::PH_WAIT_RISE: begin
                    if (i_in_data.fall_a || i_in_data.fall_b) begin
                        n_phase = ests_pkg::PH_IDLE;
                    end else if (i_in_data.rise_a && i_in_data.rise_b) begin
                        n_rise_a   = tra;
                        n_rise_b   = trb;
                        n_gap_rise = '0;
                        n_phase    = ests_pkg::PH_IDLE;
                        emit       = 1'b1;
                    end else if (i_in_data.rise_a) begin
                        n_rise_a = tra;
                        n_phase  = ests_pkg::PH_WAIT_RISE_B;
                    end else if (i_in_data.rise_b) begin
                        n_rise_b = trb;
                        n_phase  = ests_pkg::PH_WAIT_RISE_A;
                    end
                end
                ests_pkg::PH_WAIT_RISE_A: begin
                    if (i_in_data.fall_b) begin
                        n_phase = ests_pkg::PH_IDLE;
                    end else if (i_in_data.rise_a) begin
                        n_rise_a   = tra;
                        n_gap_rise = tra - r_rise_b;
                        n_phase    = ests_pkg::PH_IDLE;
                        emit       = 1'b1;
                    end
                end
                ests_pkg::PH_WAIT_RISE_B: begin
                    if (i_in_data.fall_a) begin
                        n_phase = ests_pkg::PH_IDLE;
                    end else if (i_in_data.rise_b) begin
                        n_rise_b   = trb;
                        n_gap_rise = trb - r_rise_a;
                        n_phase    = ests_pkg::PH_IDLE;
                        emit       = 1'b1;
                    end
                end
                default: begin
                    // idle: wipe the previous measurement first
                    n_fall_a   = '0;
                    n_fall_b   = '0;
                    n_rise_a   = '0;
                    n_rise_b   = '0;
                    n_gap_fall = '0;
                    n_gap_rise = '0;
                    if (i_in_data.fall_a && i_in_data.fall_b) begin
                        n_fall_a = tfa;
                        n_fall_b = tfb;
                        n_phase  = ests_pkg::PH_WAIT_RISE;
                    end else if (i_in_data.fall_a) begin
                        n_fall_a = tfa;
                        n_phase  = ests_pkg::PH_WAIT_FALL_B;
                    end else if (i_in_data.fall_b) begin
                        n_fall_b = tfb;
                        n_phase  = ests_pkg::PH_WAIT_FALL_A;
                    end else begin
                        n_phase = ests_pkg::PH_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_push_valid           = emit;
    assign o_push_data.fall_gap   = r_gap_fall;
    assign o_push_data.rise_gap   = n_gap_rise;
    assign o_push_data.order_code[ests_pkg::ORDER_FALL_BIT] = !(r_fall_b > r_fall_a);
    assign o_push_data.order_code[ests_pkg::ORDER_RISE_BIT] = !(n_rise_b > n_rise_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ests_pkg::PH_IDLE;
            r_fall_a   <= '0;
            r_fall_b   <= '0;
            r_rise_a   <= '0;
            r_rise_b   <= '0;
            r_gap_fall <= '0;
            r_gap_rise <= '0;
        end else begin
            r_phase    <= n_phase;
            r_fall_a   <= n_fall_a;
            r_fall_b   <= n_fall_b;
            r_rise_a   <= n_rise_a;
            r_rise_b   <= n_rise_b;
            r_gap_fall <= n_gap_fall;
            r_gap_rise <= n_gap_rise;
        end
    end

endmodule

// ----- rtl/ests_queue.sv -----
`timescale 1ns / 1ps

module ests_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  ests_pkg::t_meas i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output ests_pkg::t_meas o_pop_data
);

    ests_pkg::t_meas                  r_mem [ests_pkg::Q_DEPTH];
    logic [ests_pkg::Q_PTR_W-1:0]     r_wptr, n_wptr, r_rptr, n_rptr;
    logic [ests_pkg::Q_CNT_W-1:0]     r_count, n_count;
    logic                             push, pop;

    assign o_push_ready = (r_count != ests_pkg::Q_CNT_W'(ests_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == ests_pkg::Q_PTR_W'(ests_pkg::Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == ests_pkg::Q_PTR_W'(ests_pkg::Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/ests_back.sv -----
`timescale 1ns / 1ps

module ests_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  ests_pkg::t_meas i_pop_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ests_pkg::t_out  o_out_data
);

    logic            r_valid;
    ests_pkg::t_out  r_data;
    logic            load;

    // Output register refills as it drains.
    assign o_pop_ready = !r_valid || i_out_ready;
    assign load        = i_pop_valid && o_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop_ready) begin
            r_valid <= i_pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data.fall_gap   <= ests_pkg::tick_to_out(i_pop_data.fall_gap);
            r_data.rise_gap   <= ests_pkg::tick_to_out(i_pop_data.rise_gap);
            r_data.total_time <= ests_pkg::tick_sum(i_pop_data.fall_gap, i_pop_data.rise_gap);
            r_data.order_code <= i_pop_data.order_code;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ----- rtl/two_input_edge_skew_timer_core.sv -----
`timescale 1ns / 1ps

// Two-input edge skew timer. Each input transaction is one debounced edge
// event for inputs A and B (falling/rising flags plus a timestamp per edge).
// The block measures the skew between the falling edges of A and B, then
// between their rising edges; an edge that does not fit the current phase is
// either ignored or aborts the measurement, which sends the machine back to
// idle, where the stored ticks are cleared. When the second rising edge
// lands, one output transaction carries both gaps, their sum and a two-bit
// order code (bit 1 set: B did not fall later; bit 0 set: B did not rise
// later). Gaps and sum wrap modulo 2^TICK_BITS. Events that do not complete
// a measurement give no output. Throughput is one event per clock while the
// result queue has room: the front state machine decides each event as it
// is accepted. A result is written into the result queue at the accepting
// edge, then moved to the output register once that register is free. The
// input stalls only while the two-entry result queue is full, i.e. when the
// consumer has held off for a while.

module two_input_edge_skew_timer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ests_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ests_pkg::t_out o_out_data
);

    // front -> queue
    logic            push_valid, push_ready;
    ests_pkg::t_meas push_data;
    // queue -> back
    logic            pop_valid, pop_ready;
    ests_pkg::t_meas pop_data;

    // Phase machine: classifies each event, keeps ticks, forms gaps/code.
    ests_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    // Short decoupling queue so a briefly stalled consumer does not stop the front.
    ests_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Sum of gaps and registered output transaction.
    ests_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/ests_checker.sv -----
`timescale 1ns / 1ps

`include "two_input_edge_skew_timer_core_macros.svh"

module ests_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ests_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ests_pkg::t_out o_out_data
);

    logic [31:0] gap_sum;

    assign gap_sum = ests_pkg::tick_sum(o_out_data.fall_gap[ests_pkg::TICK_W-1:0],
                                        o_out_data.rise_gap[ests_pkg::TICK_W-1:0]);

    // A stalled input transaction stays offered, unchanged.
    `ESTS_ASSERT_NEXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_data))

    // A stalled result stays offered, unchanged.
    `ESTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `ESTS_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_data))

    // Nothing is offered straight out of reset.
    `ESTS_ASSERT_NEXT_ALWAYS(a_out_reset, !i_rst_n, !o_out_valid)

    // Total is the wrapped sum of the two gaps.
    `ESTS_ASSERT_NOW(a_total_sum, o_out_valid, o_out_data.total_time == gap_sum)

endmodule

bind two_input_edge_skew_timer_core ests_checker u_ests_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- test/ests_skew_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the skew timer, predicts each measurement from the
// accepted edge events and compares completed measurements in order.
module ests_skew_checker
    import ests_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    t_phase phase_q;
    t_tick  fall_a_q;
    t_tick  fall_b_q;
    t_tick  rise_a_q;
    t_tick  rise_b_q;
    t_tick  gap_fall_q;
    t_tick  gap_rise_q;

    t_out   expected_meas[$];

    task automatic clear_ticks();
        fall_a_q   = '0;
        fall_b_q   = '0;
        rise_a_q   = '0;
        rise_b_q   = '0;
        gap_fall_q = '0;
        gap_rise_q = '0;
    endtask

    // Queue the finished measurement; machine goes back to idle.
    task automatic finish_measurement();
        t_out  res;
        t_tick gap_sum;
        gap_sum        = gap_fall_q + gap_rise_q;
        res.fall_gap   = 32'(gap_fall_q);
        res.rise_gap   = 32'(gap_rise_q);
        res.total_time = 32'(gap_sum);
        res.order_code = '0;
        if (!(fall_b_q > fall_a_q))
            res.order_code[ORDER_FALL_BIT] = 1'b1;
        if (!(rise_b_q > rise_a_q))
            res.order_code[ORDER_RISE_BIT] = 1'b1;
        expected_meas.push_back(res);
        phase_q = PH_IDLE;
    endtask

    // One edge event through the measurement machine; abort tests come first.
    task automatic advance_skew_machine(input t_in ev);
        t_tick tfa;
        t_tick tfb;
        t_tick tra;
        t_tick trb;
        tfa = t_tick'(ev.fall_time_a);
        tfb = t_tick'(ev.fall_time_b);
        tra = t_tick'(ev.rise_time_a);
        trb = t_tick'(ev.rise_time_b);
        case (phase_q)
            PH_WAIT_FALL_A: begin
                if (ev.rise_b) begin
                    phase_q = PH_IDLE;
                end else if (ev.fall_a) begin
                    fall_a_q   = tfa;
                    gap_fall_q = fall_a_q - fall_b_q;
                    phase_q    = PH_WAIT_RISE;
                end
            end
            PH_WAIT_FALL_B: begin
                if (ev.rise_a) begin
                    phase_q = PH_IDLE;
                end else if (ev.fall_b) begin
                    fall_b_q   = tfb;
                    gap_fall_q = fall_b_q - fall_a_q;
                    phase_q    = PH_WAIT_RISE;
                end
            end
            PH_WAIT_RISE: begin
                if (ev.fall_a || ev.fall_b) begin
                    phase_q = PH_IDLE;
                end else if (ev.rise_a && ev.rise_b) begin
                    rise_a_q   = tra;
                    rise_b_q   = trb;
                    gap_rise_q = '0;
                    finish_measurement();
                end else if (ev.rise_a) begin
                    rise_a_q = tra;
                    phase_q  = PH_WAIT_RISE_B;
                end else if (ev.rise_b) begin
                    rise_b_q = trb;
                    phase_q  = PH_WAIT_RISE_A;
                end
            end
            PH_WAIT_RISE_A: begin
                if (ev.fall_b) begin
                    phase_q = PH_IDLE;
                end else if (ev.rise_a) begin
                    rise_a_q   = tra;
                    gap_rise_q = rise_a_q - rise_b_q;
                    finish_measurement();
                end
            end
            PH_WAIT_RISE_B: begin
                if (ev.fall_a) begin
                    phase_q = PH_IDLE;
                end else if (ev.rise_b) begin
                    rise_b_q   = trb;
                    gap_rise_q = rise_b_q - rise_a_q;
                    finish_measurement();
                end
            end
            default: begin
                clear_ticks();
                if (ev.fall_a && ev.fall_b) begin
                    fall_a_q = tfa;
                    fall_b_q = tfb;
                    phase_q  = PH_WAIT_RISE;
                end else if (ev.fall_a) begin
                    fall_a_q = tfa;
                    phase_q  = PH_WAIT_FALL_B;
                end else if (ev.fall_b) begin
                    fall_b_q = tfb;
                    phase_q  = PH_WAIT_FALL_A;
                end else begin
                    phase_q = PH_IDLE;
                end
            end
        endcase
    endtask

    task automatic compare_measurement(input t_out got);
        t_out exp_meas;
        if (expected_meas.size() == 0) begin
            $error("result transaction with nothing outstanding: %h", got);
            o_fail_count++;
        end else begin
            exp_meas = expected_meas.pop_front();
            o_checked++;
            if (got.fall_gap !== exp_meas.fall_gap) begin
                $error("fall_gap: expected %h, got %h", exp_meas.fall_gap, got.fall_gap);
                o_fail_count++;
            end
            if (got.rise_gap !== exp_meas.rise_gap) begin
                $error("rise_gap: expected %h, got %h", exp_meas.rise_gap, got.rise_gap);
                o_fail_count++;
            end
            if (got.total_time !== exp_meas.total_time) begin
                $error("total_time: expected %h, got %h",
                       exp_meas.total_time, got.total_time);
                o_fail_count++;
            end
            if (got.order_code !== exp_meas.order_code) begin
                $error("order_code: expected %0d, got %0d",
                       exp_meas.order_code, got.order_code);
                o_fail_count++;
            end
        end
    endtask

    // Push before pop so a same-cycle result still lines up with its event.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_q = PH_IDLE;
            clear_ticks();
            expected_meas.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                advance_skew_machine(i_in_data);
            if (i_out_valid && i_out_ready)
                compare_measurement(i_out_data);
        end
        o_pending = expected_meas.size();
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the edge skew timer bench. Makes the edge-event stimulus and the
// consumer back-pressure; all prediction and checking sits in the checker.
module tb_top;
    import ests_pkg::*;

    // Flag patterns, packed as {fall_a, fall_b, rise_a, rise_b}
    localparam logic [3:0] EV_NONE   = 4'b0000;
    localparam logic [3:0] EV_FALL_A = 4'b1000;
    localparam logic [3:0] EV_FALL_B = 4'b0100;
    localparam logic [3:0] EV_RISE_A = 4'b0010;
    localparam logic [3:0] EV_RISE_B = 4'b0001;

    localparam int RANDOM_EVENTS = 1000;
    localparam int HOLD_CYCLES   = 80;   // long consumer hold-off
    localparam int SETTLE_CYCLES = 10;   // idle margin before the verdict

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;

    int   fail_count;
    int   pending;
    int   checked;

    int   events_sent;
    int   stall_cycles;
    bit   no_idle;        // set during stretches where the sender never pauses
    bit   hold_request;   // sender asks the consumer for its long hold-off
    bit   hold_done;

    two_input_edge_skew_timer_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    ests_skew_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Input-side stall count, for the summary only.
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_ready)
            stall_cycles++;
    end

    // ------------------------------------------------------------------
    // Tick helpers: extremes, near neighbours (incl. wrap) and plain random
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 32'h0000_0000;
        else if (r < 20)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Partner tick of a pair: equal, just after, just before, or anywhere.
    function automatic logic [31:0] near_tick(input logic [31:0] t);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return t;
        else if (r < 60)
            return t + $urandom_range(1, 1000);
        else if (r < 80)
            return t - $urandom_range(1, 1000);
        return $urandom;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in make_event(input logic [3:0] flags,
                                       input logic [31:0] t_fa, input logic [31:0] t_fb,
                                       input logic [31:0] t_ra, input logic [31:0] t_rb);
        t_in ev;
        {ev.fall_a, ev.fall_b, ev.rise_a, ev.rise_b} = flags;
        ev.fall_time_a = t_fa;
        ev.fall_time_b = t_fb;
        ev.rise_time_a = t_ra;
        ev.rise_time_b = t_rb;
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transaction per call, entered and left at a falling edge.
    // Valid stays high across back-to-back transactions.
    // ------------------------------------------------------------------
    task automatic push_event(input t_in ev, input bit allow_gaps);
        int gap;
        in_data  <= ev;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        events_sent++;
        @(negedge clk);
        if (allow_gaps && !no_idle) begin
            gap = pick_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // Short-hand for directed events with fixed ticks.
    task automatic push_edges(input logic [3:0] flags,
                              input logic [31:0] t_fa, input logic [31:0] t_fb,
                              input logic [31:0] t_ra, input logic [31:0] t_rb);
        push_event(make_event(flags, t_fa, t_fb, t_ra, t_rb), 1'b1);
    endtask

    // Random flags and ticks: aborts, ignored flags and stray edges.
    task automatic push_noise();
        push_event(make_event(4'($urandom_range(0, 15)), pick_tick(), pick_tick(),
                              pick_tick(), pick_tick()), 1'b1);
    endtask

    // A full, well-formed measurement: both falls (either order or together),
    // then both rises. Ticks of edges not flagged are random filler.
    task automatic push_measurement(input bit allow_gaps);
        logic [31:0] f1;
        logic [31:0] f2;
        logic [31:0] r1;
        logic [31:0] r2;
        int          fall_order;
        int          rise_order;
        f1         = pick_tick();
        f2         = near_tick(f1);
        r1         = pick_tick();
        r2         = near_tick(r1);
        fall_order = $urandom_range(0, 2);
        rise_order = $urandom_range(0, 2);
        case (fall_order)
            0: begin
                push_event(make_event(EV_FALL_A, f1, $urandom, $urandom, $urandom), allow_gaps);
                push_event(make_event(EV_FALL_B, $urandom, f2, $urandom, $urandom), allow_gaps);
            end
            1: begin
                push_event(make_event(EV_FALL_B, $urandom, f1, $urandom, $urandom), allow_gaps);
                push_event(make_event(EV_FALL_A, f2, $urandom, $urandom, $urandom), allow_gaps);
            end
            default:
                push_event(make_event(EV_FALL_A | EV_FALL_B, f1, f2, $urandom, $urandom),
                           allow_gaps);
        endcase
        case (rise_order)
            0: begin
                push_event(make_event(EV_RISE_A, $urandom, $urandom, r1, $urandom), allow_gaps);
                push_event(make_event(EV_RISE_B, $urandom, $urandom, $urandom, r2), allow_gaps);
            end
            1: begin
                push_event(make_event(EV_RISE_B, $urandom, $urandom, $urandom, r1), allow_gaps);
                push_event(make_event(EV_RISE_A, $urandom, $urandom, r2, $urandom), allow_gaps);
            end
            default:
                push_event(make_event(EV_RISE_A | EV_RISE_B, $urandom, $urandom, r1, r2),
                           allow_gaps);
        endcase
    endtask

    // Drop valid and wait until every predicted measurement has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Consumer: ready in random stretches, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int  len;
        bit  ready_next;
        out_ready = 1'b0;
        hold_done = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (hold_request && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                ready_next = ($urandom_range(0, 99) < 70);
                if ($urandom_range(0, 99) < 85)
                    len = $urandom_range(1, 3);
                else
                    len = $urandom_range(10, 30);
                out_ready <= ready_next;
                repeat (len) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------
    initial begin
        int target;
        in_valid     = 1'b0;
        in_data      = '0;
        rst_n        = 1'b0;
        no_idle      = 1'b0;
        hold_request = 1'b0;
        events_sent  = 0;
        stall_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part.
        // Idle with no edges: nothing happens
        push_edges(EV_NONE, 32'h0, 32'h0, 32'h0, 32'h0);
        // A falls at zero, B at the top of the range: largest falling gap;
        // rises wrap through zero, total wraps as well
        push_edges(EV_FALL_A, 32'h0000_0000, 32'h1234_5678, 32'h0, 32'h0);
        push_edges(EV_FALL_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        push_edges(EV_RISE_A, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
        push_edges(EV_RISE_B, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        // B first on both edges, A's fall tick earlier: fall gap wraps negative
        push_edges(EV_FALL_B, 32'h0, 32'h0000_0005, 32'h0, 32'h0);
        push_edges(EV_FALL_A, 32'h0000_0003, 32'h0, 32'h0, 32'h0);
        push_edges(EV_RISE_B, 32'h0, 32'h0, 32'h0, 32'h0000_0100);
        push_edges(EV_RISE_A, 32'h0, 32'h0, 32'h0000_0200, 32'h0);
        // Both fall together, then both rise together at equal ticks
        push_edges(EV_FALL_A | EV_FALL_B, 32'h7, 32'h7, 32'h0, 32'h0);
        push_edges(EV_RISE_A | EV_RISE_B, 32'h0, 32'h0, 32'h9, 32'h9);
        // Abort waiting for B to fall: A rises again
        push_edges(EV_FALL_A, 32'h10, 32'h0, 32'h0, 32'h0);
        push_edges(EV_RISE_A | EV_FALL_B, 32'h0, 32'h11, 32'h12, 32'h0);
        // Abort waiting for A to fall: B rises, beats A's fall in the same event
        push_edges(EV_FALL_B, 32'h0, 32'h20, 32'h0, 32'h0);
        push_edges(EV_RISE_B | EV_FALL_A, 32'h21, 32'h0, 32'h0, 32'h22);
        // Abort waiting for the first rise: any fall, even with both rises set
        push_edges(4'b1111, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_edges(4'b1111, 32'h0, 32'h0, 32'h0, 32'h0);
        // Abort waiting for A to rise: B falls
        push_edges(EV_FALL_A | EV_FALL_B, 32'h30, 32'h31, 32'h0, 32'h0);
        push_edges(EV_RISE_B, 32'h0, 32'h0, 32'h0, 32'h32);
        push_edges(EV_FALL_B | EV_RISE_A, 32'h0, 32'h33, 32'h34, 32'h0);
        // Abort waiting for B to rise: A falls
        push_edges(EV_FALL_A | EV_FALL_B, 32'h40, 32'h41, 32'h0, 32'h0);
        push_edges(EV_RISE_A, 32'h0, 32'h0, 32'h42, 32'h0);
        push_edges(EV_FALL_A | EV_RISE_B, 32'h43, 32'h0, 32'h0, 32'h44);
        // Ignored flags: A's fall and B's rise are not looked at while
        // waiting for B to fall
        push_edges(EV_FALL_A, 32'h50, 32'h0, 32'h0, 32'h0);
        push_edges(EV_FALL_A | EV_FALL_B | EV_RISE_B, 32'h51, 32'h52, 32'h0, 32'h53);
        push_edges(EV_RISE_A | EV_RISE_B, 32'h0, 32'h0, 32'h60, 32'h5F);
        drain_results();

        // Random part: mostly complete measurements, some noise.
        target = events_sent + RANDOM_EVENTS;
        while (events_sent < target) begin
            if ($urandom_range(0, 19) == 0)
                no_idle = !no_idle;
            if (!hold_request && events_sent > target - RANDOM_EVENTS / 2) begin
                // Consumer holds off while measurements keep coming, so the
                // result queue fills and the input stalls; then a full drain.
                hold_request = 1'b1;
                while (!hold_done)
                    push_measurement(1'b0);
                drain_results();
            end else if ($urandom_range(0, 99) < 20) begin
                push_noise();
            end else begin
                push_measurement(1'b1);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("%0d edge events sent, %0d measurements compared", events_sent, checked);
        $display("input held back by the block for %0d cycles", stall_cycles);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ests_pkg.sv
rtl/ests_front.sv
rtl/ests_queue.sv
rtl/ests_back.sv
rtl/two_input_edge_skew_timer_core.sv
rtl/ests_checker.sv
test/ests_skew_checker.sv
test/tb_top.sv
